[hdl/dac_pkg.sv]
// ============================================================================
// dac_pkg
// Shared constants, command and status codes and state type for the direct
// access code array.
// ============================================================================
package dac_pkg;

    localparam int CHUNK_BITS_DEF = 8;
    localparam int CAPACITY_DEF   = 1024;
    localparam int LEVELS_DEF     = 4;

    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_APP   = 4'b0010,
        S_RADDR = 4'b0100,
        S_RDATA = 4'b1000
    } state_t;

endpackage

[hdl/direct_access_code_array.sv]
// ============================================================================
// direct_access_code_array
// Compressed array of 32-bit values in direct access codes, one piece per
// level in a single synchronous memory with a precomputed next-level position.
// ============================================================================
//
//  channel   direction  transfer when        payload
//  command   in         start & !busy        cmd, value, index
//  result    out        done (one cycle)     read_value, status
//
//  An append writes one piece per level in S_APP while bits remain.
//  A read visits each level in S_RADDR and then S_RDATA: each level
//  needs one memory read, whose data is registered in rdata_reg.
//  Refused appends and out-of-range reads finish straight from S_IDLE.
//  Reset clears the level counts; the memory needs no clearing.
//  The receiver cannot stall; done rises once per accepted command.
module direct_access_code_array #(
    parameter int CHUNK_BITS = dac_pkg::CHUNK_BITS_DEF,
    parameter int CAPACITY   = dac_pkg::CAPACITY_DEF,
    parameter int LEVELS     = dac_pkg::LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [dac_pkg::VALUE_W-1:0]   value,
    input  logic [dac_pkg::INDEX_W-1:0]   index,
    output logic                          done,
    output logic [dac_pkg::VALUE_W-1:0]   read_value,
    output logic [dac_pkg::STATUS_W-1:0]  status
);

    localparam int PW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int LVW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DEPTH = LEVELS * CAPACITY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(LEVELS * CHUNK_BITS + 1);
    localparam int EW    = CHUNK_BITS + 1 + PW;
    localparam int VW    = dac_pkg::VALUE_W;

    // memory entry: {piece, continue bit, position at next level}
    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rdata_reg;

    dac_pkg::state_t state_reg, state_next;
    logic [CW-1:0]  cnt_reg [LEVELS];
    logic [CW-1:0]  cnt_next [LEVELS];
    logic [LVW-1:0] level_reg, level_next;
    logic [AW-1:0]  base_reg, base_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [SW-1:0]  shift_reg, shift_next;
    logic [VW-1:0]  rest_reg, rest_next;
    logic [VW-1:0]  acc_reg, acc_next;
    logic           done_reg, done_next;
    logic [VW-1:0]  rv_reg, rv_next;
    logic [dac_pkg::STATUS_W-1:0] st_reg, st_next;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [EW-1:0]         mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [PW-1:0]         app_pos;
    logic [VW-1:0]         rest_sh;
    logic                  more;
    logic [PW-1:0]         next_cnt;
    logic [CHUNK_BITS-1:0] rd_chunk;
    logic                  rd_cont;
    logic [PW-1:0]         rd_next;
    logic                  last_level;

    // append datapath: piece of this level and count at the next level
    assign last_level = (level_reg == LVW'(LEVELS - 1));
    assign app_pos    = cnt_reg[level_reg][PW-1:0];
    assign rest_sh    = rest_reg >> CHUNK_BITS;
    assign more       = (rest_sh != '0) && !last_level;

    always_comb
    begin
        next_cnt = '0;
        for (int i = 1; i < LEVELS; i++)
        begin
            if (LVW'(i - 1) == level_reg)
            begin
                next_cnt = cnt_reg[i][PW-1:0];
            end
        end
    end

    assign mem_waddr = base_reg + AW'(app_pos);
    assign mem_wdata = {rest_reg[CHUNK_BITS-1:0], more, next_cnt};
    assign mem_raddr = base_reg + AW'(pos_reg);

    // read datapath fields
    assign rd_chunk = rdata_reg[EW-1 -: CHUNK_BITS];
    assign rd_cont  = rdata_reg[PW];
    assign rd_next  = rdata_reg[PW-1:0];

    // write and read the piece memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // sequence the levels of one command
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        level_next = level_reg;
        base_next  = base_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        rest_next  = rest_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        rv_next    = rv_reg;
        st_next    = st_reg;
        mem_we     = 1'b0;
        case (state_reg)
            dac_pkg::S_IDLE:
            begin
                if (start)
                begin
                    level_next = '0;
                    base_next  = '0;
                    shift_next = '0;
                    acc_next   = '0;
                    rest_next  = value;
                    pos_next   = PW'(index);
                    if (cmd == dac_pkg::CMD_APPEND)
                    begin
                        if (32'(cnt_reg[0]) >= 32'(CAPACITY))
                        begin
                            done_next = 1'b1;
                            rv_next   = '0;
                            st_next   = dac_pkg::ST_FULL;
                        end
                        else
                        begin
                            state_next = dac_pkg::S_APP;
                        end
                    end
                    else
                    begin
                        if (32'(index) >= 32'(cnt_reg[0]))
                        begin
                            done_next = 1'b1;
                            rv_next   = '0;
                            st_next   = dac_pkg::ST_RANGE;
                        end
                        else
                        begin
                            state_next = dac_pkg::S_RADDR;
                        end
                    end
                end
            end
            dac_pkg::S_APP:
            begin
                // store one piece, advance to the next level if bits remain
                mem_we              = 1'b1;
                cnt_next[level_reg] = cnt_reg[level_reg] + 1'b1;
                if (more)
                begin
                    level_next = level_reg + 1'b1;
                    base_next  = base_reg + AW'(CAPACITY);
                    rest_next  = rest_sh;
                end
                else
                begin
                    state_next = dac_pkg::S_IDLE;
                    done_next  = 1'b1;
                    rv_next    = '0;
                    st_next    = dac_pkg::ST_OK;
                end
            end
            dac_pkg::S_RADDR:
            begin
                state_next = dac_pkg::S_RDATA;
            end
            dac_pkg::S_RDATA:
            begin
                // merge the piece, follow the continue bit
                acc_next = acc_reg | (VW'(rd_chunk) << shift_reg);
                if (rd_cont && !last_level)
                begin
                    state_next = dac_pkg::S_RADDR;
                    level_next = level_reg + 1'b1;
                    base_next  = base_reg + AW'(CAPACITY);
                    pos_next   = rd_next;
                    shift_next = shift_reg + SW'(CHUNK_BITS);
                end
                else
                begin
                    state_next = dac_pkg::S_IDLE;
                    done_next  = 1'b1;
                    rv_next    = acc_reg | (VW'(rd_chunk) << shift_reg);
                    st_next    = dac_pkg::ST_OK;
                end
            end
            default:
            begin
                state_next = dac_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dac_pkg::S_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < LEVELS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        base_reg  <= base_next;
        pos_reg   <= pos_next;
        shift_reg <= shift_next;
        rest_reg  <= rest_next;
        acc_reg   <= acc_next;
        rv_reg    <= rv_next;
        st_reg    <= st_next;
    end

    assign busy       = (state_reg != dac_pkg::S_IDLE);
    assign done       = done_reg;
    assign read_value = rv_reg;
    assign status     = st_reg;

endmodule

[hdl/dac_checker.sv]
// ============================================================================
// dac_checker
// Port-level checks on the command and result transfers of the array.
// ============================================================================
module dac_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [dac_pkg::VALUE_W-1:0]   read_value,
    input logic [dac_pkg::STATUS_W-1:0]  status
);

    // a result only ever follows an accepted command or a busy cycle
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start) || $past(busy)))
        else $error("result without a command");

    // no result while a command is still walking the levels
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    // refused or out-of-range commands return zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != dac_pkg::ST_OK) |-> (read_value == '0))
        else $error("nonzero value with error status");

    // status holds a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == dac_pkg::ST_OK || status == dac_pkg::ST_FULL
                  || status == dac_pkg::ST_RANGE))
        else $error("undefined status code");

endmodule

bind direct_access_code_array dac_checker u_dac_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .read_value (read_value),
    .status     (status)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Checks the direct access code array: appends and reads are issued through
// the start/busy command port, and every done strobe is compared against a
// local model of the levelled piece store with rank-based next positions.
// ============================================================================
module tb_top;

    localparam int CHUNK   = dac_pkg::CHUNK_BITS_DEF;
    localparam int CAP     = dac_pkg::CAPACITY_DEF;
    localparam int NLEV    = dac_pkg::LEVELS_DEF;
    localparam int N_RAND  = 928;
    localparam int MAX_CYC = 2000000;

    typedef struct packed {
        logic                         cmd;
        logic [dac_pkg::VALUE_W-1:0]  value;
        logic [dac_pkg::INDEX_W-1:0]  index;
    } dac_cmd_t;

    typedef struct packed {
        logic [dac_pkg::VALUE_W-1:0]  read_value;
        logic [dac_pkg::STATUS_W-1:0] status;
    } dac_rsp_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         cmd;
    logic [dac_pkg::VALUE_W-1:0]  value;
    logic [dac_pkg::INDEX_W-1:0]  index;
    logic                         done;
    logic [dac_pkg::VALUE_W-1:0]  read_value;
    logic [dac_pkg::STATUS_W-1:0] status;

    direct_access_code_array uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .value      (value),
        .index      (index),
        .done       (done),
        .read_value (read_value),
        .status     (status)
    );

    // Model of the stored levels
    logic [CHUNK-1:0] piece_mem [NLEV][CAP];
    bit               cont_mem  [NLEV][CAP];
    int unsigned      lvl_count [NLEV];

    dac_cmd_t    cmd_queue[$];
    dac_rsp_t    expected_rsp[$];
    int          err_count = 0;
    int          cycle_count = 0;
    int          gap_left = 0;

    always #6 clk = ~clk;

    // Append one command to the pending queue
    function automatic void queue_cmd(dac_cmd_t c);
        cmd_queue = {cmd_queue, c};
    endfunction

    function automatic int unsigned rank_to(int lv, int unsigned pos);
        int unsigned n;
        n = 0;
        for (int unsigned i = 0; i <= pos && i < CAP; i++)
            n += cont_mem[lv][i];
        return n;
    endfunction

    // Update the model state and return the expected response
    function automatic dac_rsp_t apply_command(dac_cmd_t c);
        dac_rsp_t       r;
        logic [63:0]    rest;
        logic [63:0]    acc;
        int unsigned    pos;
        bit             more;
        r.read_value = '0;
        r.status = dac_pkg::ST_OK;
        if (c.cmd == dac_pkg::CMD_APPEND)
        begin
            if (lvl_count[0] >= CAP)
            begin
                r.status = dac_pkg::ST_FULL;
                return r;
            end
            rest = 64'(c.value);
            pos = lvl_count[0];
            for (int lv = 0; lv < NLEV; lv++)
            begin
                if (pos >= CAP)
                    break;
                piece_mem[lv][pos] = rest[CHUNK-1:0];
                rest = rest >> CHUNK;
                more = (rest != 0) && (lv + 1 < NLEV);
                cont_mem[lv][pos] = more;
                lvl_count[lv] = pos + 1;
                if (!more)
                    break;
                pos = rank_to(lv, pos) - 1;
            end
        end
        else
        begin
            if (32'(c.index) >= lvl_count[0])
            begin
                r.status = dac_pkg::ST_RANGE;
                return r;
            end
            acc = '0;
            pos = 32'(c.index);
            for (int lv = 0; lv < NLEV; lv++)
            begin
                if (pos >= CAP)
                    break;
                if (lv * CHUNK < 32)
                    acc |= 64'(piece_mem[lv][pos]) << (lv * CHUNK);
                if (!cont_mem[lv][pos])
                    break;
                pos = rank_to(lv, pos) - 1;
            end
            r.read_value = acc[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 255);
            1: return $urandom_range(256, 65535);
            2: return $urandom_range(0, 32'hFFFFFF);
            3: return 32'h1 << $urandom_range(0, 31);
            4: return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    // Driver: hold start until a transfer, then wait a random gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= dac_pkg::CMD_APPEND;
            value <= '0;
            index <= '0;
            gap_left <= 0;
        end
        else if (start && !busy)
        begin
            expected_rsp = {expected_rsp, apply_command({cmd, value, index})};
            if (gap_left == 0 && cmd_queue.size() > 0)
            begin
                {cmd, value, index} <= cmd_queue.pop_front();
                gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
            end
            else
            begin
                start <= 1'b0;
            end
        end
        else if (!start)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (cmd_queue.size() > 0)
            begin
                {cmd, value, index} <= cmd_queue.pop_front();
                start <= 1'b1;
                gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
            end
        end
    end

    // Monitor: compare every done strobe against the oldest expectation
    always @(posedge clk)
    begin
        dac_rsp_t e;
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected result: read_value %h status %0d", read_value, status);
                err_count++;
            end
            else
            begin
                e = expected_rsp.pop_front();
                if (read_value !== e.read_value)
                begin
                    $error("read_value expected %h actual %h", e.read_value, read_value);
                    err_count++;
                end
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status);
                    err_count++;
                end
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        if (cycle_count >= MAX_CYC)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        dac_cmd_t c;
        int       appended;
        clk = 1'b0;
        rst_n = 1'b0;

        // Directed: reads on empty, edge values, last-level drop, wide values
        queue_cmd({dac_pkg::CMD_READ, 32'h0, 10'd0});
        queue_cmd({dac_pkg::CMD_READ, 32'hFFFFFFFF, 10'd1023});
        queue_cmd({dac_pkg::CMD_APPEND, 32'h0, 10'h3FF});
        queue_cmd({dac_pkg::CMD_APPEND, 32'hFFFFFFFF, 10'd0});
        queue_cmd({dac_pkg::CMD_APPEND, 32'h000000FF, 10'd0});
        queue_cmd({dac_pkg::CMD_APPEND, 32'h00000100, 10'd0});
        queue_cmd({dac_pkg::CMD_APPEND, 32'h00FF0000, 10'd0});
        queue_cmd({dac_pkg::CMD_APPEND, 32'h80000000, 10'd0});
        queue_cmd({dac_pkg::CMD_APPEND, 32'h55AA55AA, 10'd0});
        queue_cmd({dac_pkg::CMD_APPEND, 32'hAA55AA55, 10'd0});
        for (int i = 0; i < 8; i++)
            queue_cmd({dac_pkg::CMD_READ, 32'hFFFFFFFF * (i % 2), 10'(i)});
        queue_cmd({dac_pkg::CMD_READ, 32'h0, 10'd8});
        queue_cmd({dac_pkg::CMD_READ, 32'h0, 10'd1023});
        appended = 8;

        // Random: mixed appends and reads, mostly at valid indexes
        for (int n = 0; n < N_RAND; n++)
        begin
            c.value = rand_value();
            c.index = 10'($urandom_range(0, 1023));
            if ($urandom_range(0, 9) < 6 && appended < CAP + 20)
            begin
                c.cmd = dac_pkg::CMD_APPEND;
                appended++;
            end
            else
            begin
                c.cmd = dac_pkg::CMD_READ;
                if ($urandom_range(0, 7) != 0 && appended > 0)
                    c.index = 10'($urandom_range(0, (appended > CAP ? CAP : appended) - 1));
            end
            queue_cmd(c);
        end
        queue_cmd({dac_pkg::CMD_READ, 32'h0, 10'd1023});
        queue_cmd({dac_pkg::CMD_READ, 32'h0, 10'd0});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (cmd_queue.size() == 0 && !start);
        wait (expected_rsp.size() == 0);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
